/* src/spq_pkg.sv */
// Shared types and constants of the sorted priority queue.
// Used by spq_cfg, spq_ctrl, spq_datapath and sorted_priority_queue.
package spq_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int unsigned DEPTH_DEF         = 16;
  localparam int unsigned ELEMENT_BITS_DEF  = 16;
  localparam int unsigned PRIORITY_BITS_DEF = 16;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_STATUS  = 2'd0,
    CMD_ENQUEUE = 2'd1,
    CMD_DEQUEUE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_ENQ_FULL   = 2'd1,
    ST_DEQ_EMPTY  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_CAPACITY_LIMIT = 2'd0,
    REG_SMALLER_FIRST  = 2'd1,
    REG_MATCH_MASK     = 2'd2
  } reg_idx_e;

  localparam logic [CAP_W-1:0]  CAPACITY_RST = 5'd16;
  localparam logic              SMALLER_RST  = 1'b0;
  localparam logic [MASK_W-1:0] MASK_RST     = 16'hFFFF;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_RESP
  } fsm_state_e;

  typedef struct packed {
    logic [CAP_W-1:0]  capacity_limit;
    logic              smaller_first;
    logic [MASK_W-1:0] match_mask;
  } cfg_t;

  typedef struct packed {
    logic load;   // capture the input beat
    logic exec;   // apply the command and build the result
  } ctrl_t;

endpackage

/* src/spq_cfg.sv */
// APB-style register file: capacity_limit, smaller_first, match_mask.
// Depends on spq_pkg.
module spq_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spq_pkg::APB_AW-1:0]   paddr,
  input  logic [spq_pkg::APB_DW-1:0]   pwdata,
  output logic [spq_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output spq_pkg::cfg_t                cfg_o
);
  import spq_pkg::*;

  logic [CAP_W-1:0]  capacity_q;
  logic              smaller_q;
  logic [MASK_W-1:0] mask_q;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RST;
      smaller_q  <= SMALLER_RST;
      mask_q     <= MASK_RST;
    end else if (wr_en) begin
      case (idx)
        REG_CAPACITY_LIMIT: capacity_q <= pwdata[CAP_W-1:0];
        REG_SMALLER_FIRST:  smaller_q  <= pwdata[0];
        REG_MATCH_MASK:     mask_q     <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_CAPACITY_LIMIT: prdata = APB_DW'(capacity_q);
      REG_SMALLER_FIRST:  prdata = APB_DW'(smaller_q);
      REG_MATCH_MASK:     prdata = APB_DW'(mask_q);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.capacity_limit = capacity_q;
  assign cfg_o.smaller_first  = smaller_q;
  assign cfg_o.match_mask     = mask_q;

endmodule

/* src/spq_ctrl.sv */
// Controller of the queue: accept, execute, respond sequence.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output spq_pkg::ctrl_t ctrl_o
);
  import spq_pkg::*;

  fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (in_valid_i) state_d = FSM_EXEC;
      FSM_EXEC: state_d = FSM_RESP;
      FSM_RESP: if (out_ready_i) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctrl_o      = '0;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      FSM_EXEC: ctrl_o.exec = 1'b1;
      FSM_RESP: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

/* src/spq_datapath.sv */
// Sorted cell array with per-cell compare and shift, plus result register.
// Depends on spq_pkg; driven by spq_ctrl.
module spq_datapath #(
  parameter int unsigned DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int unsigned ELEMENT_BITS  = spq_pkg::ELEMENT_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int unsigned CNT_W         = $clog2(DEPTH + 1),
  parameter int unsigned RES_W         = 2 * ELEMENT_BITS + PRIORITY_BITS + CNT_W + 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  spq_pkg::ctrl_t                  ctrl_i,
  input  spq_pkg::cfg_t                   cfg_i,
  input  logic [spq_pkg::CMD_W-1:0]       cmd_i,
  input  logic [ELEMENT_BITS-1:0]         elem_i,
  input  logic [PRIORITY_BITS-1:0]        prio_i,
  output logic [RES_W-1:0]                res_o
);
  import spq_pkg::*;

  localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned MW     = (ELEMENT_BITS > MASK_W) ? ELEMENT_BITS : MASK_W;

  cmd_e                     cmd_q;
  logic [ELEMENT_BITS-1:0]  elem_in_q;
  logic [PRIORITY_BITS-1:0] prio_in_q;

  logic [ELEMENT_BITS-1:0]  elem_q [DEPTH];
  logic [ELEMENT_BITS-1:0]  elem_d [DEPTH];
  logic [PRIORITY_BITS-1:0] prio_q [DEPTH];
  logic [PRIORITY_BITS-1:0] prio_d [DEPTH];
  logic [CNT_W-1:0]         count_q, count_d;
  logic [RES_W-1:0]         res_q, res_d;

  logic [CMP_W-1:0]         cap_ext, cap_eff, cnt_ext, cnt_next_ext;
  logic [MW-1:0]            mask_wide;
  logic [ELEMENT_BITS-1:0]  eff_mask;
  logic [DEPTH-1:0]         valid, ahead, match;
  logic [DEPTH:0]           ahead_ext;
  logic                     ahead_run;
  logic                     full, empty, enq_ok, deq_ok, found;
  status_e                  status;
  logic [ELEMENT_BITS-1:0]  dequeued, head_elem;
  logic [PRIORITY_BITS-1:0] head_prio;

  // capture the input beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q     <= cmd_e'(cmd_i);
      elem_in_q <= elem_i;
      prio_in_q <= prio_i;
    end
  end

  assign cap_ext   = CMP_W'(cfg_i.capacity_limit);
  assign cap_eff   = (cap_ext < CMP_W'(DEPTH)) ? cap_ext : CMP_W'(DEPTH);
  assign cnt_ext   = CMP_W'(count_q);
  assign full      = cnt_ext >= cap_eff;
  assign empty     = (count_q == '0);
  assign mask_wide = MW'(cfg_i.match_mask);
  assign eff_mask  = mask_wide[ELEMENT_BITS-1:0];

  // per-cell compares; a cell stays ahead only while every cell before it does
  always_comb begin
    ahead_run = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = CNT_W'(i) < count_q;
      ahead_run = ahead_run && valid[i] &&
                  (cfg_i.smaller_first ? (prio_q[i] <= prio_in_q)
                                       : (prio_q[i] >= prio_in_q));
      ahead[i] = ahead_run;
      match[i] = valid[i] && (((elem_q[i] ^ elem_in_q) & eff_mask) == '0);
    end
  end

  assign ahead_ext = {ahead, 1'b1};
  assign enq_ok    = ctrl_i.exec && (cmd_q == CMD_ENQUEUE) && !full;
  assign deq_ok    = ctrl_i.exec && (cmd_q == CMD_DEQUEUE) && !empty;

  // next cell contents: hold, insert, shift back or shift forward
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      elem_d[i] = elem_q[i];
      prio_d[i] = prio_q[i];
      if (enq_ok && !ahead[i]) begin
        if (ahead_ext[i]) begin
          elem_d[i] = elem_in_q;
          prio_d[i] = prio_in_q;
        end else if (i > 0) begin
          elem_d[i] = elem_q[(i > 0) ? i - 1 : 0];
          prio_d[i] = prio_q[(i > 0) ? i - 1 : 0];
        end
      end else if (deq_ok && (i < DEPTH - 1)) begin
        elem_d[i] = elem_q[(i < DEPTH - 1) ? i + 1 : i];
        prio_d[i] = prio_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (deq_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // result fields, taken from the state after this command
  always_comb begin
    status = ST_OK;
    case (cmd_q)
      CMD_ENQUEUE: if (full)  status = ST_ENQ_FULL;
      CMD_DEQUEUE: if (empty) status = ST_DEQ_EMPTY;
      default:     status = ST_OK;
    endcase
    found        = (cmd_q == CMD_QUERY) && (|match);
    dequeued     = deq_ok ? elem_q[0] : '0;
    head_elem    = (count_d != '0) ? elem_d[0] : '0;
    head_prio    = (count_d != '0) ? prio_d[0] : '0;
    cnt_next_ext = CMP_W'(count_d);
    res_d = {status, found, (cnt_next_ext >= cap_eff), (count_d == '0),
             count_d, head_prio, head_elem, dequeued};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      elem_q[i] <= elem_d[i];
      prio_q[i] <= prio_d[i];
    end
    if (ctrl_i.exec) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* src/sorted_priority_queue.sv */
// Top level of the sorted priority queue: registers, controller, datapath.
// Depends on spq_pkg, spq_cfg, spq_ctrl and spq_datapath.
// Usage
//   Commands arrive as beats on the s_axis channel (status, enqueue,
//   dequeue, membership query). Every command beat yields exactly one
//   result beat on m_axis with the dequeued element, the head entry, the
//   entry count, the empty and full flags, the query hit and a status code.
//   Entries are kept sorted in a row of cells; an enqueue lands behind all
//   entries of higher or equal priority, so ties leave in arrival order.
// Timing
//   One command at a time: accept cycle, execute cycle, then the result
//   beat is offered from the cycle after and held until the receiver takes
//   it; the controller's accept, execute, respond sequence sets this order.
//   The cell array does the search and shift of one command in the execute
//   state.
// Stall and reset
//   While m_axis_tready is low the result holds and s_axis_tready stays
//   low. Reset empties the queue, loads the register defaults (capacity 16,
//   larger value first, full match mask) and idles the controller.
// Registers (APB): 0x0 capacity_limit, 0x4 smaller_first, 0x8 match_mask; write when idle.
module sorted_priority_queue #(
  parameter int unsigned DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int unsigned ELEMENT_BITS  = spq_pkg::ELEMENT_BITS_DEF,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  parameter int unsigned CNT_W         = $clog2(DEPTH + 1),
  parameter int unsigned IN_W  = ((spq_pkg::CMD_W + ELEMENT_BITS + PRIORITY_BITS + 7) / 8) * 8,
  parameter int unsigned RES_W = 2 * ELEMENT_BITS + PRIORITY_BITS + CNT_W + 5,
  parameter int unsigned OUT_W = ((RES_W + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // s_axis_tdata, low bit up: command, element_in, priority_in, zero pad
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [IN_W-1:0]             s_axis_tdata,
  // m_axis_tdata, low bit up: dequeued_element, head_element,
  // head_priority, entry_count, is_empty, is_full, found, status, zero pad
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [OUT_W-1:0]            m_axis_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spq_pkg::APB_AW-1:0]  paddr,
  input  logic [spq_pkg::APB_DW-1:0]  pwdata,
  output logic [spq_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import spq_pkg::*;

  localparam int unsigned ELEM_LO = CMD_W;
  localparam int unsigned PRIO_LO = CMD_W + ELEMENT_BITS;

  cfg_t             cfg;
  ctrl_t            ctrl;
  logic [RES_W-1:0] res;

  spq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequence accept, execute and respond
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  spq_datapath #(
    .DEPTH         (DEPTH),
    .ELEMENT_BITS  (ELEMENT_BITS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .CNT_W         (CNT_W),
    .RES_W         (RES_W)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cfg_i  (cfg),
    .cmd_i  (s_axis_tdata[CMD_W-1:0]),
    .elem_i (s_axis_tdata[PRIO_LO-1:ELEM_LO]),
    .prio_i (s_axis_tdata[PRIO_LO+PRIORITY_BITS-1:PRIO_LO]),
    .res_o  (res)
  );

  // pad the result to whole bytes
  assign m_axis_tdata = OUT_W'(res);

endmodule
